/* rtl/vtda_pkg.sv */
package vtda_pkg;

	// Store sizes
	localparam int MAX_ROWS   = 64;
	localparam int MAX_COLS   = 64;
	localparam int MAX_SLICES = 8;

	localparam int ACC_DEPTH = MAX_SLICES * MAX_COLS;
	localparam int ACC_AW    = $clog2(ACC_DEPTH);
	localparam int VEC_AW    = $clog2(MAX_ROWS);

	// Field widths
	localparam int OP_W     = 2;
	localparam int SLICE_W  = 3;
	localparam int ROW_W    = 6;
	localparam int COL_W    = 6;
	localparam int VAL_W    = 32;
	localparam int ACC_W    = 48;
	localparam int STATUS_W = 2;
	localparam int PROD_W   = 2 * VAL_W;

	// Configuration register widths
	localparam int SLICES_CFG_W = 4;
	localparam int ROWS_CFG_W   = 7;
	localparam int COLS_CFG_W   = 7;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 7;

	// Stream packing
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 56;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_ACC   = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_SAT   = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SLICES = 2'd0,
		CFG_ROWS   = 2'd1,
		CFG_COLS   = 2'd2
	} cfg_idx_t;

	// Stage enables for the multiply-accumulate datapath
	typedef struct packed {
		logic mul_en;
		logic rnd_en;
	} mac_ctl_t;

endpackage

/* rtl/vtda_ram.sv */
module vtda_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/vtda_mac.sv */
module vtda_mac (
	input  logic                                  clk,
	input  vtda_pkg::mac_ctl_t                    ctl,
	input  logic signed [vtda_pkg::VAL_W-1:0]     vec,
	input  logic signed [vtda_pkg::VAL_W-1:0]     value,
	input  logic signed [vtda_pkg::ACC_W-1:0]     acc,
	output logic signed [vtda_pkg::ACC_W-1:0]     sum,
	output logic                                  sat
);
	import vtda_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] rounded;
	logic signed [ACC_W-1:0]  term_s2;
	logic signed [ACC_W:0]    wide_sum;

	// Q16.16 times Q16.16 into a Q32.32 product
	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= vec * value;
		end
	end

	// Round half up to Q32.16
	assign rounded = (prod_s1 + PROD_W'(32768)) >>> 16;

	always_ff @(posedge clk) begin
		if (ctl.rnd_en) begin
			term_s2 <= rounded[ACC_W-1:0];
		end
	end

	// Add and clamp to the 48-bit range
	assign wide_sum = {acc[ACC_W-1], acc} + {term_s2[ACC_W-1], term_s2};
	assign sat      = wide_sum[ACC_W] != wide_sum[ACC_W-1];

	always_comb begin
		if (!sat) begin
			sum = wide_sum[ACC_W-1:0];
		end else if (wide_sum[ACC_W]) begin
			sum = ACC_MIN;
		end else begin
			sum = ACC_MAX;
		end
	end

endmodule

/* rtl/vector_tensor_dot_accumulate.sv */
// Vector-tensor multiply-accumulate: out[col][slice] += vec[row] * tensor[slice][row][col]
// in Q16.16 with saturating Q32.16 accumulators, held in a 64-entry vector RAM and a
// 512-entry accumulator RAM (entry slice*64+col). The block works on one transfer at a
// time. A vector load or an index error goes from idle straight to the finish state, a read
// passes through the multiply state for the RAM read, and an accumulate passes through the
// RAM read, the registered multiply and the rounding stage before the saturating add and
// write-back. The finish state loads the result into the output register, waiting while the
// result side stalls, and the next input transfer is taken once it is loaded. A clear walks
// the accumulator RAM one entry per cycle and then finishes the same way; the same sweep
// runs after reset, without a result, and s_tready stays low during it.
// An index at or above its configured size answers status 1 and changes nothing. Write the
// size registers only while no transfer is in flight.
module vector_tensor_dot_accumulate (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [2:0] slice_index, [8:3] row_index, [14:9] col_index, [46:15] value, [47] zero
	input  logic [vtda_pkg::S_TDATA_W-1:0]      s_tdata,
	// [1:0] op
	input  logic [vtda_pkg::OP_W-1:0]           s_tuser,
	// Result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [47:0] read_value, [49:48] status, [55:50] zero
	output logic [vtda_pkg::M_TDATA_W-1:0]      m_tdata,
	// Configuration writes
	input  logic                                cfg_we,
	input  logic [vtda_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vtda_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import vtda_pkg::*;

	typedef enum logic [4:0] {
		S_CLR  = 5'b00001,
		S_IDLE = 5'b00010,
		S_MUL  = 5'b00100,
		S_RND  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	logic [SLICES_CFG_W-1:0] slices_q;
	logic [ROWS_CFG_W-1:0]   rows_q;
	logic [COLS_CFG_W-1:0]   cols_q;

	logic [SLICE_W-1:0]      in_slice;
	logic [ROW_W-1:0]        in_row;
	logic [COL_W-1:0]        in_col;
	logic signed [VAL_W-1:0] in_value;
	op_t                     in_op;
	logic                    accept;
	logic                    slice_ok, row_ok, col_ok, item_ok;
	logic [ACC_AW-1:0]       in_addr;
	logic [VEC_AW-1:0]       in_vaddr;

	op_t                     op_q;
	logic                    ok_q;
	logic [ACC_AW-1:0]       addr_q;
	logic signed [VAL_W-1:0] value_q;
	logic                    vec_ok_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [MAX_ROWS-1:0]     vec_vld_q;
	logic [ACC_AW-1:0]       clr_cnt_q;
	logic                    clr_report_q;
	logic                    clr_last;

	logic                    out_valid_q;
	logic [M_TDATA_W-1:0]    out_data_q;
	logic                    out_free;
	logic                    fin_go;

	logic                    vec_we, vec_re;
	logic [VAL_W-1:0]        vec_rdata;
	logic signed [VAL_W-1:0] vec_eff;
	logic                    acc_we, acc_re;
	logic [ACC_AW-1:0]       acc_waddr;
	logic [ACC_W-1:0]        acc_wdata;
	logic [ACC_W-1:0]        acc_rdata;

	mac_ctl_t                mac_ctl;
	logic signed [ACC_W-1:0] mac_sum;
	logic                    mac_sat;

	status_t                 res_status;
	logic [ACC_W-1:0]        res_value;

	// Unpack the input transfer
	assign in_slice = s_tdata[2:0];
	assign in_row   = s_tdata[8:3];
	assign in_col   = s_tdata[14:9];
	assign in_value = s_tdata[46:15];
	assign in_op    = op_t'(s_tuser);

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Index limits: below the register and below the store size
	assign slice_ok = (int'(in_slice) < int'(slices_q)) && (int'(in_slice) < MAX_SLICES);
	assign row_ok   = (int'(in_row) < int'(rows_q)) && (int'(in_row) < MAX_ROWS);
	assign col_ok   = (int'(in_col) < int'(cols_q)) && (int'(in_col) < MAX_COLS);

	always_comb begin
		case (in_op)
			OP_LOAD: item_ok = row_ok;
			OP_ACC:  item_ok = slice_ok && row_ok && col_ok;
			OP_READ: item_ok = slice_ok && col_ok;
			default: item_ok = 1'b1;
		endcase
	end

	assign in_addr  = ACC_AW'(int'(in_slice) * MAX_COLS + int'(in_col));
	assign in_vaddr = VEC_AW'(in_row);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slices_q <= SLICES_CFG_W'(MAX_SLICES);
			rows_q   <= ROWS_CFG_W'(MAX_ROWS);
			cols_q   <= COLS_CFG_W'(MAX_COLS);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SLICES: slices_q <= cfg_data[SLICES_CFG_W-1:0];
				CFG_ROWS:   rows_q   <= cfg_data[ROWS_CFG_W-1:0];
				CFG_COLS:   cols_q   <= cfg_data[COLS_CFG_W-1:0];
				default:    ;
			endcase
		end
	end

	// Vector RAM: write on a load, read on an accumulate
	assign vec_we = accept && (in_op == OP_LOAD) && row_ok;
	assign vec_re = accept && (in_op == OP_ACC) && item_ok;

	vtda_ram #(
		.WIDTH(VAL_W),
		.DEPTH(MAX_ROWS)
	) u_vec_ram (
		.clk  (clk),
		.we   (vec_we),
		.waddr(in_vaddr),
		.wdata(in_value),
		.re   (vec_re),
		.raddr(in_vaddr),
		.rdata(vec_rdata)
	);

	// Rows never loaded read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_vld_q <= '0;
		end else if (vec_we) begin
			vec_vld_q[in_vaddr] <= 1'b1;
		end
	end

	assign vec_eff = vec_ok_q ? signed'(vec_rdata) : '0;

	// Accumulator RAM: cleared by the sweep, updated at the end of an accumulate
	assign clr_last = (clr_cnt_q == ACC_AW'(ACC_DEPTH - 1));
	assign out_free = !out_valid_q || m_tready;
	assign fin_go   = (state_q == S_FIN) && out_free;
	assign acc_re   = accept && ((in_op == OP_ACC) || (in_op == OP_READ)) && item_ok;
	assign acc_we   = (state_q == S_CLR) || (fin_go && (op_q == OP_ACC) && ok_q);
	assign acc_waddr = (state_q == S_CLR) ? clr_cnt_q : addr_q;
	assign acc_wdata = (state_q == S_CLR) ? '0 : mac_sum;

	vtda_ram #(
		.WIDTH(ACC_W),
		.DEPTH(ACC_DEPTH)
	) u_acc_ram (
		.clk  (clk),
		.we   (acc_we),
		.waddr(acc_waddr),
		.wdata(acc_wdata),
		.re   (acc_re),
		.raddr(in_addr),
		.rdata(acc_rdata)
	);

	// Multiply, round, add
	assign mac_ctl.mul_en = (state_q == S_MUL);
	assign mac_ctl.rnd_en = (state_q == S_RND);

	vtda_mac u_mac (
		.clk  (clk),
		.ctl  (mac_ctl),
		.vec  (vec_eff),
		.value(value_q),
		.acc  (acc_q),
		.sum  (mac_sum),
		.sat  (mac_sat)
	);

	// Hold the item's operands
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q   <= in_addr;
			value_q  <= in_value;
			vec_ok_q <= vec_vld_q[in_vaddr];
		end
		if (state_q == S_MUL) begin
			acc_q <= signed'(acc_rdata);
		end
	end

	// Sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR: begin
				if (clr_last) begin
					state_d = clr_report_q ? S_FIN : S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (in_op == OP_CLEAR) begin
						state_d = S_CLR;
					end else if (item_ok && (in_op != OP_LOAD)) begin
						state_d = S_MUL;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_MUL: begin
				state_d = (op_q == OP_READ) ? S_FIN : S_RND;
			end
			S_RND: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_cnt_q    <= '0;
			clr_report_q <= 1'b0;
			op_q         <= OP_CLEAR;
			ok_q         <= 1'b1;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q         <= in_op;
				ok_q         <= item_ok;
				clr_cnt_q    <= '0;
				clr_report_q <= 1'b1;
			end else if (state_q == S_CLR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// Result of the finished item
	always_comb begin
		res_value = '0;
		if (!ok_q) begin
			res_status = ST_RANGE;
		end else if ((op_q == OP_ACC) && mac_sat) begin
			res_status = ST_SAT;
		end else begin
			res_status = ST_OK;
		end
		if ((op_q == OP_READ) && ok_q) begin
			res_value = acc_q;
		end
	end

	// Output register: load on finish, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_data_q <= {(M_TDATA_W - ACC_W - STATUS_W)'(0), res_status, res_value};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

/* rtl/vtda_checker.sv */
module vtda_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [vtda_pkg::M_TDATA_W-1:0]  m_tdata
);
	import vtda_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// One item at a time: no input transfer right after another
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in flight");

	// Status carries a defined code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[49:48] == ST_OK) || (m_tdata[49:48] == ST_RANGE)
			|| (m_tdata[49:48] == ST_SAT))
		else $error("undefined status code");

	// A failed or saturated item reads back zero
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[49:48] != ST_OK) |-> m_tdata[47:0] == '0)
		else $error("nonzero read value with error status");

endmodule

bind vector_tensor_dot_accumulate vtda_checker u_vtda_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
